FILE: design/tffp_pkg.sv
// Package for the tagged frame field parser: byte codes, parser phase type
// and the item struct passed from the input register to the parser core.
// No dependencies.
`default_nettype none

package tffp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned WORD_COUNT = 4;
   localparam int unsigned IDX_W      = 2;

   localparam logic [BYTE_W-1:0] BYTE_OPEN  = 8'h23;  // '#'
   localparam logic [BYTE_W-1:0] BYTE_CLOSE = 8'h24;  // '$'
   localparam logic [BYTE_W-1:0] BYTE_TAG_A = 8'h41;  // 'A'
   localparam logic [BYTE_W-1:0] BYTE_TAG_D = 8'h44;  // 'D'

   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_TAG     = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              buffer_start;
   } item_type;

endpackage : tffp_pkg

`default_nettype wire

FILE: design/tffp_core.sv
// Parser core: phase state machine and the four field words.
// Depends on tffp_pkg.
`default_nettype none

module tffp_core (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       fire,
   input  wire tffp_pkg::item_type                         item,
   output logic                                            emit,
   output logic [tffp_pkg::WORD_COUNT*tffp_pkg::WORD_W-1:0] words
);
   import tffp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  word_ff, word_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [WORD_W-1:0] words_ff [WORD_COUNT];
   logic              wr_en;
   phase_type         phase_eff;
   logic [BYTE_W-1:0] tag_off;

   assign tag_off   = item.rx_byte - BYTE_TAG_A;
   // buffer start forces hunting before the byte is looked at
   assign phase_eff = item.buffer_start ? PHASE_HUNT : phase_ff;

   always_comb begin
      phase_in = phase_ff;
      word_in  = word_ff;
      slot_in  = slot_ff;
      wr_en    = 1'b0;
      emit     = 1'b0;
      if (fire) begin
         case (phase_eff)
            PHASE_HUNT: begin
               phase_in = (item.rx_byte == BYTE_OPEN) ? PHASE_TAG : PHASE_HUNT;
            end
            PHASE_TAG: begin
               if (item.rx_byte >= BYTE_TAG_A && item.rx_byte <= BYTE_TAG_D) begin
                  phase_in = PHASE_PAYLOAD;
                  word_in  = tag_off[IDX_W-1:0];
                  slot_in  = '0;
               end else begin
                  phase_in = PHASE_HUNT;
                  emit     = (item.rx_byte == BYTE_CLOSE);
               end
            end
            PHASE_PAYLOAD: begin
               wr_en   = 1'b1;
               slot_in = slot_ff + 1'b1;
               if (slot_ff == '1) begin
                  phase_in = PHASE_TAG;
               end
            end
            default: begin
               phase_in = PHASE_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         word_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         word_ff  <= word_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORD_COUNT; i++) begin
            words_ff[i] <= '0;
         end
      end else if (wr_en) begin
         words_ff[word_ff][slot_ff*BYTE_W +: BYTE_W] <= item.rx_byte;
      end
   end

   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         words[i*WORD_W +: WORD_W] = words_ff[i];
      end
   end

endmodule : tffp_core

`default_nettype wire

FILE: design/tagged_frame_field_parser.sv
// Top level of the tagged frame field parser: input register, parser core,
// result register. Depends on tffp_pkg and tffp_core.
`default_nettype none

// Takes one received byte per transfer on the req_ stream. A '#' opens a
// frame; each tag byte 'A'..'D' is followed by four payload bytes written,
// least significant byte first, into one of four 32-bit words (A: long
// speed, B: lateral speed, C: heading rate, D: steering). A '$' in tag
// position closes the frame and sends all four words as one rsp_ transfer;
// any other tag byte drops back to hunting for '#'. req_tuser high marks the
// first byte of a new buffer and forces hunting before that byte is parsed.
// Words keep their values across frames and reset to zero. Throughput is
// one byte per clock while the rsp_ side does not stall: a byte is held in
// the input register while the parser core updates its phase and words,
// and a closing '$' then loads the result register, which drives rsp_tvalid.
// The input register and the result register each hold a transfer while
// the rsp_ side stalls, so req_tready stays high until both are full.
module tagged_frame_field_parser (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  wire logic         req_tuser,   // [0] buffer_start
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // [31:0] long_speed_bits,
                                          // [63:32] lateral_speed_bits,
                                          // [95:64] heading_rate_bits,
                                          // [127:96] steering_bits
);
   import tffp_pkg::*;

   logic                             in_valid_ff;
   item_type                         in_item_ff;
   logic                             rsp_valid_ff;
   logic [WORD_COUNT*WORD_W-1:0]     rsp_data_ff;
   logic                             advance;
   logic                             req_xfer;
   logic                             emit;
   logic [WORD_COUNT*WORD_W-1:0]     words;

   // advance the core whenever the result slot is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.rx_byte      <= req_tdata;
         in_item_ff.buffer_start <= req_tuser;
      end
   end

   tffp_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (in_valid_ff && advance),
      .item  (in_item_ff),
      .emit  (emit),
      .words (words)
   );

   // result register: snapshot the words when '$' closes a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= words;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_result_from_close: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_item_ff.rx_byte == BYTE_CLOSE))
      else $error("result without a closing byte");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input register changed while stalled");

   a_ready_only_when_room: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff))
      else $error("ready dropped with room available");
`endif

endmodule : tagged_frame_field_parser

`default_nettype wire
